// ===== sv/irca_pkg.sv =====
// ----------------------------------------------------------------------------
// irca_pkg
// Shared types and constants for the int8 requantized channel add block.
// ----------------------------------------------------------------------------
package irca_pkg;

  // Command codes, carried on in_tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  localparam int SCALE_W   = 24;   // unsigned Q8.F scale
  localparam int VAL_W     = 8;    // int8 element
  localparam int CHAN_W    = 8;    // channel field / channel counter
  localparam int CCOUNT_W  = 9;    // channel_count register
  localparam int IN_DATA_W = 96;   // packed input word
  localparam int OUT_DATA_W = 8;   // packed result word

  // One table row: three scales side by side.
  typedef struct packed {
    logic [SCALE_W-1:0] inv_scale;
    logic [SCALE_W-1:0] scale_b;
    logic [SCALE_W-1:0] scale_a;
  } scale_row_t;

  localparam int ROW_W = $bits(scale_row_t);

  localparam logic [CCOUNT_W-1:0] CCOUNT_MAX = 9'd256;

  // Clamp limits.
  localparam logic signed [VAL_W-1:0] RES_MAX = 8'sd127;
  localparam logic signed [VAL_W-1:0] RES_MIN = -8'sd128;

endpackage

// ===== sv/int8_requantized_channel_add.sv =====
// ----------------------------------------------------------------------------
// int8_requantized_channel_add
// Per-channel requantized addition of two int8 tensor streams.
// ----------------------------------------------------------------------------
// Each data word carries an int8 pair (a, b) for the current channel c; the
// block returns clamp(round(((a*scale_a[c] + b*scale_b[c]) * inv_scale[c])
// / 2^(2*SCALE_FRAC_BITS))) with rounding half away from zero, a saturation
// flag and the tlast copy. Scales are unsigned Q8.F and sit in one
// MAX_CHANNELS x 72-bit RAM (three scales per row), written by load words
// (in_tuser = 0); loads produce no result. Channels are taken in order:
// the counter advances per data word, wraps at channel_count and restarts
// after a word with tlast. A data word passes through the RAM read, the two
// 8x25 products, their sum and the 34x25 scale product, with round/clamp on
// the way into the output register, which it enters only when that register
// is empty or being read; the block takes one data word at a time and is
// ready again after its result has moved into the output register.
// in_tready is low only while a data word is in flight, and a result waiting
// in the output register does not block the next input. Scales of a channel
// must be loaded before data of that channel arrives; the RAM is not cleared
// at reset.
// ----------------------------------------------------------------------------
module int8_requantized_channel_add #(
  parameter int MAX_CHANNELS    = 256,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // cfg: channel_count
  input  logic                            cfg_wr_en,
  input  logic [irca_pkg::CCOUNT_W-1:0]   cfg_wr_data,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] channel, [15:8] value_a, [23:16] value_b, [47:24] scale_a,
  // [71:48] scale_b, [95:72] scale_out
  input  logic [irca_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,   // [0] command
  input  logic                            in_tlast,   // end_of_tensor
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [irca_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] sum_out
  output logic                            out_tuser,  // [0] saturated
  output logic                            out_tlast   // last
);

  import irca_pkg::*;

  localparam int AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PROD_W  = 33;                 // int8 x unsigned 24
  localparam int SUM_W   = PROD_W + 1;
  localparam int SI_W    = SCALE_W + 1;        // signed view of inv scale
  localparam int FULL_W  = SUM_W + SI_W;
  localparam int RND_W   = FULL_W + 1;
  localparam int SHIFT   = 2 * SCALE_FRAC_BITS;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // Input unpacking
  logic [CHAN_W-1:0]  in_chan;
  logic [VAL_W-1:0]   in_a;
  logic [VAL_W-1:0]   in_b;
  scale_row_t         in_row;
  assign in_chan          = in_tdata[7:0];
  assign in_a             = in_tdata[15:8];
  assign in_b             = in_tdata[23:16];
  assign in_row.scale_a   = in_tdata[47:24];
  assign in_row.scale_b   = in_tdata[71:48];
  assign in_row.inv_scale = in_tdata[95:72];

  logic in_acc, load_acc, data_acc;
  assign in_acc   = in_tvalid && in_tready;
  assign load_acc = in_acc && (in_tuser == CMD_LOAD);
  assign data_acc = in_acc && (in_tuser == CMD_DATA);

  // Config and control state
  logic [CCOUNT_W-1:0] ccount_r;
  logic [CHAN_W-1:0]   chan_idx_r, chan_idx_nxt;
  logic [2:0]          state_r, state_nxt;

  // Scale RAM
  logic       load_ok;
  logic       ram_we;
  scale_row_t rd_row;
  logic [ROW_W-1:0] rd_bits;
  assign load_ok = 32'(in_chan) < MAX_CHANNELS;
  assign ram_we  = load_acc && load_ok;

  irca_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_CHANNELS)
  ) u_scale_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (AW'(in_chan)),
    .wr_data (in_row),
    .rd_en   (data_acc),
    .rd_addr (AW'(chan_idx_r)),
    .rd_data (rd_bits)
  );
  assign rd_row = rd_bits;

  // Channel counter: wraps at channel_count (0 or >256 acts as 256).
  logic [CCOUNT_W-1:0] limit;
  logic [CCOUNT_W-1:0] next_c;
  always_comb begin
    limit = ccount_r;
    if (ccount_r == '0 || ccount_r > CCOUNT_MAX) begin
      limit = CCOUNT_MAX;
    end
    next_c       = {1'b0, chan_idx_r} + 1'b1;
    chan_idx_nxt = chan_idx_r;
    if (data_acc) begin
      if (in_tlast || next_c >= limit) begin
        chan_idx_nxt = '0;
      end else begin
        chan_idx_nxt = next_c[CHAN_W-1:0];
      end
    end
  end

  // Datapath registers (no reset)
  logic signed [VAL_W-1:0]  a_r, b_r;
  logic                     eot_r;
  logic                     rng_r;       // channel inside the table
  logic signed [PROD_W-1:0] pa_r, pb_r;
  logic signed [SI_W-1:0]   si_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [FULL_W-1:0] prod_r;

  // Scales of an out-of-table channel read as zero.
  logic [SCALE_W-1:0] sa, sb, si;
  assign sa = rng_r ? rd_row.scale_a   : '0;
  assign sb = rng_r ? rd_row.scale_b   : '0;
  assign si = rng_r ? rd_row.inv_scale : '0;

  // Round half away from zero, then clamp.
  logic              neg;
  logic [FULL_W-1:0] mag;
  logic [RND_W-1:0]  rnd;
  logic [RND_W-1:0]  q;
  logic [VAL_W-1:0]  res;
  logic              sat;
  always_comb begin
    neg = prod_r[FULL_W-1];
    mag = neg ? FULL_W'(-prod_r) : FULL_W'(prod_r);
    rnd = {1'b0, mag} + (RND_W'(1) << (SHIFT - 1));
    q   = rnd >> SHIFT;
    sat = 1'b0;
    if (neg) begin
      if (q > RND_W'(128)) begin
        sat = 1'b1;
        res = RES_MIN;
      end else begin
        res = VAL_W'(-q[VAL_W-1:0]);
      end
    end else begin
      if (q > RND_W'(127)) begin
        sat = 1'b1;
        res = RES_MAX;
      end else begin
        res = q[VAL_W-1:0];
      end
    end
  end

  // Output register
  logic             out_valid_r;
  logic [VAL_W-1:0] out_sum_r;
  logic             out_sat_r;
  logic             out_last_r;
  logic             out_load;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (data_acc) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccount_r    <= CCOUNT_MAX;
      chan_idx_r  <= '0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ccount_r <= cfg_wr_data;
      end
      chan_idx_r <= chan_idx_nxt;
      state_r    <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      a_r   <= in_a;
      b_r   <= in_b;
      eot_r <= in_tlast;
      rng_r <= 32'(chan_idx_r) < MAX_CHANNELS;
    end
    if (state_r == ST_MUL) begin
      pa_r <= a_r * $signed({1'b0, sa});
      pb_r <= b_r * $signed({1'b0, sb});
      si_r <= $signed({1'b0, si});
    end
    if (state_r == ST_SUM) begin
      sum_r <= SUM_W'(pa_r) + SUM_W'(pb_r);
    end
    if (state_r == ST_SCALE) begin
      prod_r <= sum_r * si_r;
    end
    if (out_load) begin
      out_sum_r  <= res;
      out_sat_r  <= sat;
      out_last_r <= eot_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/irca_ram.sv =====
// ----------------------------------------------------------------------------
// irca_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module irca_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
